### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the spectrum level meter. Each use names its own
// label and message; clock and reset come from the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define SLPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside of reset.
`define SLPT_ASSERT_NEVER(lbl, expr, msg) \
    `SLPT_ASSERT(lbl, !(expr), msg)

`endif

### rtl/core/slpt_pkg.sv
// ----------------------------------------------------------------------------
// slpt_pkg
// Types, codes and constants shared by the spectrum level meter modules.
// ----------------------------------------------------------------------------
package slpt_pkg;

    // Stream word widths
    localparam int S_DATA_W = 16;   // channel, rssi_dbm
    localparam int S_USER_W = 3;    // operation, sweep_start
    localparam int M_DATA_W = 40;   // channel_out, level, peak, strongest_*

    localparam int CH_W    = 7;
    localparam int PCT_W   = 7;
    localparam int RSSI_W  = 8;
    localparam int GAIN_W  = 3;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 1;

    localparam logic [PCT_W-1:0]         PCT_MAX    = 7'd100;
    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = -8'sd88;
    localparam logic signed [RSSI_W-1:0] RSSI_CEIL  = -8'sd25;
    localparam logic signed [RSSI_W-1:0] BEST_RESET = -8'sd120;
    localparam logic [GAIN_W-1:0]        GAIN_RESET = 3'd2;
    localparam logic [COUNT_W-1:0]       COUNT_RESET = 8'd128;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_GAIN          = 1'b0;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic {
        UPD_SAMPLE = 1'b0,
        UPD_TICK   = 1'b1
    } upd_kind_t;

    typedef struct packed {
        upd_kind_t        kind;
        logic [PCT_W-1:0] pct;
        logic [PCT_W-1:0] lvl;
        logic [PCT_W-1:0] pk;
    } upd_in_t;

    typedef struct packed {
        logic [PCT_W-1:0] lvl;
        logic [PCT_W-1:0] pk;
    } upd_out_t;

    // Percent for rssi offsets 0..63 above the floor: offset*100/63
    typedef logic [63:0][PCT_W-1:0] pct_lut_t;

    function automatic pct_lut_t build_pct_lut();
        pct_lut_t t;
        for (int i = 0; i < 64; i++)
        begin
            t[i] = PCT_W'(i * 100 / 63);
        end
        return t;
    endfunction

    localparam pct_lut_t PCT_LUT = build_pct_lut();

endpackage

### rtl/core/slpt_update.sv
// ----------------------------------------------------------------------------
// slpt_update
// Per-entry update unit shared by samples and peak decay ticks.
// ----------------------------------------------------------------------------
module slpt_update (
    input  slpt_pkg::upd_in_t  upd_in,
    output slpt_pkg::upd_out_t upd_out
);
    import slpt_pkg::*;

    logic [8:0]       blend;
    logic [PCT_W-1:0] lvl_new;

    // level jumps up at once, otherwise decays toward the new value
    assign blend = ({2'b00, upd_in.lvl} * 9'd3) + {2'b00, upd_in.pct};

    always_comb
    begin
        if (upd_in.pct > upd_in.lvl)
        begin
            lvl_new = upd_in.pct;
        end
        else
        begin
            lvl_new = blend[8:2];
        end
    end

    always_comb
    begin
        unique case (upd_in.kind)
            UPD_SAMPLE:
            begin
                upd_out.lvl = lvl_new;
                upd_out.pk  = (lvl_new > upd_in.pk) ? lvl_new : upd_in.pk;
            end
            UPD_TICK:
            begin
                upd_out.lvl = upd_in.lvl;
                upd_out.pk  = (upd_in.pk > upd_in.lvl) ? upd_in.pk - 7'd1 : upd_in.pk;
            end
            default:
            begin
                upd_out.lvl = upd_in.lvl;
                upd_out.pk  = upd_in.pk;
            end
        endcase
    end

endmodule

### rtl/core/spectrum_level_peak_tracker.sv
// A sample word goes through these steps from acceptance until the block is
// ready again: the read of the channel's level/peak entry from the store, then
// the shared update unit, which runs and writes it back. A decay tick walks the
// channels in use through the same unit, a read and a write step per channel;
// a clear writes zeros to all MAX_CHANNELS entries, one per cycle. After reset
// the block runs the same clearing pass before it takes its first word. A
// finished result sits in the output register and does not hold off the next
// input word, but a sample that reaches its update step while that result
// still waits holds there until the result is taken.
// ----------------------------------------------------------------------------
// spectrum_level_peak_tracker
// Per-channel spectrum meter with smoothed level, peak hold and strongest
// signal tracking per sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_level_peak_tracker #(
    parameter int MAX_CHANNELS = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [slpt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [slpt_pkg::CFG_W-1:0]    cfg_data,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slpt_pkg::S_DATA_W-1:0] s_tdata,   // channel[6:0], rssi_dbm[14:7]
    input  logic [slpt_pkg::S_USER_W-1:0] s_tuser,   // operation[1:0], sweep_start[2]
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // channel_out[6:0], level[13:7], peak[20:14], strongest_channel[27:21],
    // strongest_rssi[35:28]
    output logic [slpt_pkg::M_DATA_W-1:0] m_tdata
);
    import slpt_pkg::*;

    localparam int AW = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_CHANNELS - 1);

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_READ    = 6'b000100,
        S_CALC    = 6'b001000,
        S_TICK_RD = 6'b010000,
        S_TICK_WR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]  gain_reg;
    logic [COUNT_W-1:0] channel_count_reg;

    logic [AW-1:0]      idx_reg, idx_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [RSSI_W-1:0]  rssi_reg, rssi_next;
    logic               sweep_reg, sweep_next;
    logic [PCT_W-1:0]   pct_reg, pct_next;

    logic signed [RSSI_W-1:0] best_rssi_reg, best_rssi_next;
    logic [CH_W-1:0]          best_channel_reg, best_channel_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // level in [13:7], peak in [6:0]
    logic [2*PCT_W-1:0] store_mem [MAX_CHANNELS];
    logic [2*PCT_W-1:0] rd_word_reg;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [2*PCT_W-1:0] wr_word;
    logic               mem_we;

    logic [WW-1:0]  cc_ext, used;
    logic [AW-1:0]  used_last;
    op_t            in_op;
    logic [CH_W-1:0] in_ch;
    logic           in_valid_ch;
    logic           calc_go;

    logic signed [RSSI_W-1:0] rssi_s;
    logic signed [RSSI_W-1:0] base_rssi;
    logic [CH_W-1:0]          base_ch;
    logic [5:0]               pct_off;
    logic [9:0]               pct_raw;

    upd_in_t  upd_in;
    upd_out_t upd_out;

    // channels in use
    assign cc_ext    = WW'(channel_count_reg);
    assign used      = (cc_ext > WW'(MAX_CHANNELS)) ? WW'(MAX_CHANNELS) : cc_ext;
    assign used_last = AW'(used - WW'(1));

    assign in_op       = op_t'(s_tuser[1:0]);
    assign in_ch       = s_tdata[6:0];
    assign in_valid_ch = WW'(in_ch) < used;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign calc_go = !m_tvalid_reg || m_tready;

    // rssi to percent: table lookup then gain, clamped later
    assign rssi_s = $signed(rssi_reg);
    always_comb
    begin
        if (rssi_s <= RSSI_FLOOR)
        begin
            pct_off = 6'd0;
        end
        else if (rssi_s > RSSI_CEIL)
        begin
            pct_off = 6'd63;
        end
        else
        begin
            pct_off = 6'(rssi_s - RSSI_FLOOR);
        end
    end
    assign pct_raw = {3'b000, PCT_LUT[pct_off]} * {7'd0, gain_reg};

    // strongest-signal tracking
    assign base_rssi = sweep_reg ? BEST_RESET : best_rssi_reg;
    assign base_ch   = sweep_reg ? '0 : best_channel_reg;

    assign upd_in.kind = (state_reg == S_CALC) ? UPD_SAMPLE : UPD_TICK;
    assign upd_in.pct  = pct_reg;
    assign upd_in.lvl  = rd_word_reg[2*PCT_W-1:PCT_W];
    assign upd_in.pk   = rd_word_reg[PCT_W-1:0];

    slpt_update u_update (
        .upd_in  (upd_in),
        .upd_out (upd_out)
    );

    // keep the sampled entry on the read port while the update step stalls
    assign rd_addr = ((state_reg == S_READ) || (state_reg == S_CALC)) ? AW'(ch_reg)
                                                                      : idx_reg;
    assign wr_addr = (state_reg == S_CALC) ? AW'(ch_reg) : idx_reg;
    assign wr_word = (state_reg == S_CLEAR) ? '0 : {upd_out.lvl, upd_out.pk};
    assign mem_we  = (state_reg == S_CLEAR) || (state_reg == S_TICK_WR)
                     || ((state_reg == S_CALC) && calc_go);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        ch_next           = ch_reg;
        rssi_next         = rssi_reg;
        sweep_next        = sweep_reg;
        pct_next          = pct_reg;
        best_rssi_next    = best_rssi_reg;
        best_channel_next = best_channel_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_ENTRY)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next = '0;
                    unique case (in_op)
                        OP_SAMPLE:
                        begin
                            if (in_valid_ch)
                            begin
                                ch_next    = in_ch;
                                rssi_next  = s_tdata[14:7];
                                sweep_next = s_tuser[2];
                                state_next = S_READ;
                            end
                        end
                        OP_TICK:
                        begin
                            if (used != '0)
                            begin
                                state_next = S_TICK_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                pct_next   = (pct_raw > 10'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (calc_go)
                begin
                    best_rssi_next    = base_rssi;
                    best_channel_next = base_ch;
                    if (rssi_s > base_rssi)
                    begin
                        best_rssi_next    = rssi_s;
                        best_channel_next = ch_reg;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, best_rssi_next, best_channel_next,
                                     upd_out.pk, upd_out.lvl, ch_reg};
                    state_next    = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_WR;
            end
            S_TICK_WR:
            begin
                idx_next   = idx_reg + AW'(1);
                state_next = S_TICK_RD;
                if (idx_reg == used_last)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            idx_reg           <= '0;
            gain_reg          <= GAIN_RESET;
            channel_count_reg <= COUNT_RESET;
            best_rssi_reg     <= BEST_RESET;
            best_channel_reg  <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            best_rssi_reg    <= best_rssi_next;
            best_channel_reg <= best_channel_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_GAIN:          gain_reg          <= cfg_data[GAIN_W-1:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[COUNT_W-1:0];
                    default:           gain_reg          <= gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        rssi_reg    <= rssi_next;
        sweep_reg   <= sweep_next;
        pct_reg     <= pct_next;
        m_tdata_reg <= m_tdata_next;
    end

    // level stays within range and never above the held peak
    `SLPT_ASSERT(a_level_peak, m_tvalid |-> (m_tdata[13:7] <= PCT_MAX) && (m_tdata[20:14] >= m_tdata[13:7]), "level above peak or range")
    // the update stage is only reached through the read stage
    `SLPT_ASSERT(a_calc_after_read, (state_reg == S_CALC) && !$past(state_reg == S_CALC) |-> $past(state_reg == S_READ), "update without read")
    // tick walk stays inside the channels in use
    `SLPT_ASSERT_NEVER(a_tick_bound, ((state_reg == S_TICK_RD) || (state_reg == S_TICK_WR)) && (idx_reg > used_last), "tick index out of range")

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spectrum_level_peak_tracker. An in-bench model of the
// level/peak stores and sweep tracking predicts every result word. Input
// traffic comes in random bursts, and the result side stalls in changing
// patterns. A directed part covers the mapping edges, tick, clear and
// out-of-range cases. The random part then runs sweeps under several gain and
// channel count settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import slpt_pkg::*;

    localparam int MAX_CH       = 128;
    localparam int SPAN_DBM     = RSSI_CEIL - RSSI_FLOOR;
    // longest internal walk (decay tick over all channels) plus margin
    localparam int SETTLE_CYCLES = 2 * MAX_CH + 32;

    typedef struct {
        logic [CH_W-1:0]          ch;
        logic [PCT_W-1:0]         lvl;
        logic [PCT_W-1:0]         pk;
        logic [CH_W-1:0]          top_ch;
        logic signed [RSSI_W-1:0] top_rssi;
    } meter_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // channel[6:0], rssi_dbm[14:7]
    logic [S_USER_W-1:0] s_tuser;    // operation[1:0], sweep_start[2]
    logic                m_tvalid;
    logic                m_tready;
    // channel_out[6:0], level[13:7], peak[20:14], strongest_channel[27:21],
    // strongest_rssi[35:28]
    logic [M_DATA_W-1:0] m_tdata;

    // meter model state
    logic [PCT_W-1:0]         level_mem [MAX_CH];
    logic [PCT_W-1:0]         peak_mem  [MAX_CH];
    logic signed [RSSI_W-1:0] top_rssi;
    logic [CH_W-1:0]          top_ch;
    logic [GAIN_W-1:0]        gain_r;
    logic [COUNT_W-1:0]       count_r;

    meter_result_t meter_results_q [$];
    int            fail_count;
    int            useful_words;
    int            burst_left;

    spectrum_level_peak_tracker #(
        .MAX_CHANNELS (MAX_CH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int used_channels();
        return (count_r > MAX_CH) ? MAX_CH : int'(count_r);
    endfunction

    // Applies one accepted word to the model; returns 1 unless the block ignores it.
    function automatic bit update_meter_model(op_t op, logic [CH_W-1:0] ch,
                                              logic signed [RSSI_W-1:0] rssi,
                                              logic sweep);
        int            used;
        int            r;
        int            pct;
        int            lvl;
        meter_result_t res;
        used = used_channels();
        case (op)
            OP_TICK:
            begin
                for (int i = 0; i < used; i++)
                begin
                    if (peak_mem[i] > level_mem[i])
                        peak_mem[i] = peak_mem[i] - 1'b1;
                end
                return used != 0;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < MAX_CH; i++)
                begin
                    level_mem[i] = '0;
                    peak_mem[i]  = '0;
                end
                return 1'b1;
            end
            OP_SAMPLE:
            begin
                if (int'(ch) >= used)
                    return 1'b0;
                r = rssi;
                if (r <= RSSI_FLOOR)
                    pct = 0;
                else
                begin
                    if (r > RSSI_CEIL)
                        r = RSSI_CEIL;
                    pct = (r - RSSI_FLOOR) * 100 / SPAN_DBM;
                    pct = pct * int'(gain_r);
                    if (pct > PCT_MAX)
                        pct = PCT_MAX;
                end
                if (sweep)
                begin
                    top_rssi = BEST_RESET;
                    top_ch   = '0;
                end
                lvl = level_mem[ch];
                if (pct > lvl)
                    lvl = pct;
                else
                    lvl = (lvl * 3 + pct) / 4;
                level_mem[ch] = PCT_W'(lvl);
                if (PCT_W'(lvl) > peak_mem[ch])
                    peak_mem[ch] = PCT_W'(lvl);
                if (rssi > top_rssi)
                begin
                    top_rssi = rssi;
                    top_ch   = ch;
                end
                res.ch       = ch;
                res.lvl      = PCT_W'(lvl);
                res.pk       = peak_mem[ch];
                res.top_ch   = top_ch;
                res.top_rssi = top_rssi;
                meter_results_q.push_back(res);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Sends one word in bursts with random gaps; valid stays up inside a burst.
    task automatic send_word(op_t op, logic [CH_W-1:0] ch,
                             logic signed [RSSI_W-1:0] rssi, logic sweep);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rssi, ch};
        s_tuser  <= {sweep, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        if (update_meter_model(op, ch, rssi, sweep))
            useful_words++;
    endtask

    task automatic send_sample(logic [CH_W-1:0] ch, int rssi, logic sweep);
        send_word(OP_SAMPLE, ch, RSSI_W'(rssi), sweep);
    endtask

    task automatic send_control(op_t op);
        send_word(op, CH_W'($urandom), RSSI_W'($urandom), 1'($urandom));
    endtask

    // Drains all results and lets tick/clear walks finish before any config write.
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (meter_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_GAIN)
            gain_r = val[GAIN_W-1:0];
        else
            count_r = val;
        @(posedge clk);
    endtask

    task automatic test_mapping_and_tracking();
        // weak values below the reset best never take over, equal ones neither
        send_sample(7'd0, -128, 1'b1);
        send_sample(7'd1, -121, 1'b0);
        send_sample(7'd1, -120, 1'b0);
        send_sample(7'd2, -119, 1'b0);
        send_sample(7'd127, 127, 1'b0);
        send_sample(7'd3, 127, 1'b0);
        // floor, just above floor, ceiling, above ceiling
        send_sample(7'd5, -88, 1'b0);
        send_sample(7'd6, -87, 1'b0);
        send_sample(7'd7, -25, 1'b0);
        send_sample(7'd8, -24, 1'b0);
        // lower value decays level, peak holds; ticks pull peak down
        send_sample(7'd8, -60, 1'b0);
        send_control(OP_TICK);
        send_sample(7'd8, -60, 1'b0);
        send_control(OP_TICK);
        send_control(OP_TICK);
        send_control(OP_NONE);
        send_control(OP_CLEAR);
        send_sample(7'd8, -60, 1'b1);
        send_sample(7'd127, -128, 1'b0);
    endtask

    task automatic test_register_edges();
        wait_idle();
        write_reg(REG_GAIN, 8'd0);
        write_reg(REG_CHANNEL_COUNT, 8'd4);
        send_sample(7'd3, -30, 1'b0);
        // out of range: ignored, including its sweep flag
        send_sample(7'd4, -30, 1'b1);
        send_sample(7'd127, 100, 1'b1);
        send_control(OP_TICK);
        wait_idle();
        // upper data bits beyond the gain width are dropped
        write_reg(REG_GAIN, 8'hFF);
        write_reg(REG_CHANNEL_COUNT, 8'd0);
        send_sample(7'd0, -40, 1'b1);
        send_control(OP_TICK);
        wait_idle();
        write_reg(REG_GAIN, 8'd6);
        write_reg(REG_CHANNEL_COUNT, 8'd255);
        send_sample(7'd127, -70, 1'b1);
        send_sample(7'd64, -50, 1'b0);
        send_control(OP_TICK);
    endtask

    function automatic logic signed [RSSI_W-1:0] pick_rssi();
        if ($urandom_range(0, 4) != 0)
            return RSSI_W'(int'($urandom_range(0, 85)) - 100);
        return RSSI_W'($urandom);
    endfunction

    // Mostly well-formed sweeps with random levels, plus ticks, clears and noise.
    task automatic run_sweeps(int target, int max_words);
        int words;
        int goal;
        int used;
        int len;
        int start;
        int sel;
        words = 0;
        goal  = useful_words + target;
        while (useful_words < goal && words < max_words)
        begin
            used = used_channels();
            sel  = $urandom_range(0, 99);
            if (sel < 70 && used != 0)
            begin
                len   = $urandom_range(1, 24);
                start = $urandom_range(0, used - 1);
                for (int k = 0; k < len; k++)
                begin
                    send_word(OP_SAMPLE, CH_W'((start + k) % used), pick_rssi(),
                              k == 0);
                    if ($urandom_range(0, 29) == 0)
                        send_control(OP_TICK);
                end
                words += len;
            end
            else if (sel < 82)
            begin
                send_control(OP_TICK);
                words++;
            end
            else if (sel < 85)
            begin
                send_control(OP_CLEAR);
                words++;
            end
            else if (sel < 90)
            begin
                send_control(OP_NONE);
                words++;
            end
            else
            begin
                send_word(op_t'($urandom_range(0, 3)), CH_W'($urandom),
                          RSSI_W'($urandom), 1'($urandom));
                words++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int gains  [10] = '{2, 1, 5, 3, 7, 0, 6, 4, 1, 5};
        int counts [10] = '{128, 128, 37, 2, 128, 20, 255, 129, 1, 100};
        for (int p = 0; p < 10; p++)
        begin
            wait_idle();
            write_reg(REG_GAIN, CFG_W'(gains[p]));
            write_reg(REG_CHANNEL_COUNT, CFG_W'(counts[p]));
            run_sweeps(120, 900);
        end
    endtask

    // result side: stall pattern changes mode after a random run
    initial
    begin
        int mode;
        int left;
        int phase;
        mode  = 0;
        left  = 0;
        phase = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 400);
            end
            left--;
            phase++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((phase % 7) < 3);
                default: m_tready <= 1'($urandom);
            endcase
        end
    end

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        meter_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (meter_results_q.size() == 0)
            begin
                $error("result word with no expectation pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                e = meter_results_q.pop_front();
                check_field("channel_out", e.ch, m_tdata[6:0]);
                check_field("level", e.lvl, m_tdata[13:7]);
                check_field("peak", e.pk, m_tdata[20:14]);
                check_field("strongest_channel", e.top_ch, m_tdata[27:21]);
                check_field("strongest_rssi", e.top_rssi, $signed(m_tdata[35:28]));
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        useful_words = 0;
        burst_left   = 0;
        for (int i = 0; i < MAX_CH; i++)
        begin
            level_mem[i] = '0;
            peak_mem[i]  = '0;
        end
        top_rssi = BEST_RESET;
        top_ch   = '0;
        gain_r   = GAIN_RESET;
        count_r  = COUNT_RESET;

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_GAIN;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_mapping_and_tracking();
        test_register_edges();
        test_random_traffic();
        wait_idle();

        if (fail_count == 0 && meter_results_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/slpt_pkg.sv
rtl/core/slpt_update.sv
rtl/core/spectrum_level_peak_tracker.sv
sim/testbench.sv
